@@ hdl/mexp_pkg.sv @@
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int WIDTH_DEFAULT = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_ROUND,
        ST_MUL,
        ST_SQR,
        ST_FINISH
    } state_t;

    // Which modular product the shared multiplier works on this cycle
    typedef enum logic [1:0] {
        OP_NONE,
        OP_REDUCE,
        OP_MUL,
        OP_SQR
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
        logic e_shift;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic mul_last;
        logic e_zero;
        logic e_bit0;
    } sts_t;

endpackage

@@ hdl/mexp_datapath.sv @@
`timescale 1ns / 1ps

module mexp_datapath #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               modulus_wr_en,
    input  logic [WIDTH-1:0]   modulus_wr_data,
    input  logic [WIDTH-1:0]   base_value,
    input  logic [WIDTH-1:0]   exponent,
    input  mexp_pkg::cmd_t     cmd,
    output mexp_pkg::sts_t     sts,
    output logic [WIDTH-1:0]   power_result
);

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] mod_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] e_reg;
    logic [WIDTH-1:0] r_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] mpd_reg;
    logic [WIDTH-1:0] mpr_reg;
    logic [WIDTH-1:0] res_reg;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;

    logic             mod_zero;
    logic             step;
    logic             last;
    logic [WIDTH-1:0] mpd_cur;
    logic [WIDTH-1:0] mpr_cur;
    logic [WIDTH-1:0] acc_cur;
    logic [WIDTH-1:0] dbl;
    logic [WIDTH-1:0] acc_next;

    // (x + y) mod m for x, y below m; a zero modulus wraps to WIDTH bits
    function automatic logic [WIDTH-1:0] add_mod(
        input logic [WIDTH-1:0] x,
        input logic [WIDTH-1:0] y,
        input logic [WIDTH-1:0] m,
        input logic             wrap
    );
        logic [WIDTH:0] s;
        logic [WIDTH:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = s - {1'b0, m};
        if (wrap)
            add_mod = s[WIDTH-1:0];
        else if (s >= {1'b0, m})
            add_mod = d[WIDTH-1:0];
        else
            add_mod = s[WIDTH-1:0];
    endfunction

    assign mod_zero = (mod_reg == '0);
    assign step     = (cmd.op != mexp_pkg::OP_NONE);
    assign last     = (cnt_reg == CW'(WIDTH - 1));

    // First step of a product takes its operands straight from the source registers (a constant 1 for the reduction)
    always_comb
    begin
        case (cmd.op)
            mexp_pkg::OP_REDUCE: mpd_cur = WIDTH'(1);
            mexp_pkg::OP_MUL:    mpd_cur = r_reg;
            mexp_pkg::OP_SQR:    mpd_cur = b_reg;
            default:             mpd_cur = b_reg;
        endcase
        if (cnt_reg != '0)
        begin
            mpd_cur = mpd_reg;
        end
        mpr_cur  = (cnt_reg == '0) ? b_reg : mpr_reg;
        acc_cur  = (cnt_reg == '0) ? '0 : acc_reg;
        dbl      = add_mod(acc_cur, acc_cur, mod_reg, mod_zero);
        acc_next = mpr_cur[WIDTH-1] ? add_mod(dbl, mpd_cur, mod_reg, mod_zero) : dbl;
        cnt_next = last ? '0 : cnt_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= WIDTH'(1);
            cnt_reg <= '0;
        end
        else
        begin
            if (modulus_wr_en)
            begin
                mod_reg <= modulus_wr_data;
            end
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (step)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            b_reg <= base_value;
            e_reg <= exponent;
            r_reg <= WIDTH'(1);
        end
        else
        begin
            if (step)
            begin
                acc_reg <= acc_next;
                mpd_reg <= mpd_cur;
                mpr_reg <= {mpr_cur[WIDTH-2:0], 1'b0};
                // Retire the finished product into its destination
                if (last)
                begin
                    if (cmd.op == mexp_pkg::OP_MUL)
                        r_reg <= acc_next;
                    else
                        b_reg <= acc_next;
                end
            end
            if (cmd.e_shift)
            begin
                e_reg <= {1'b0, e_reg[WIDTH-1:1]};
            end
        end
        if (cmd.out_load)
        begin
            res_reg <= r_reg;
        end
    end

    assign sts.mul_last  = last;
    assign sts.e_zero    = (e_reg == '0);
    assign sts.e_bit0    = e_reg[0];
    assign power_result  = res_reg;

endmodule

@@ hdl/mexp_ctrl.sv @@
`timescale 1ns / 1ps

module mexp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  mexp_pkg::sts_t   sts,
    output mexp_pkg::cmd_t   cmd
);

    mexp_pkg::state_t state_reg;
    mexp_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.op         = mexp_pkg::OP_NONE;
        case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = mexp_pkg::ST_REDUCE;
                end
            end
            mexp_pkg::ST_REDUCE:
            begin
                cmd.op = mexp_pkg::OP_REDUCE;
                if (sts.mul_last)
                    state_next = mexp_pkg::ST_ROUND;
            end
            mexp_pkg::ST_ROUND:
            begin
                // Stop once no set exponent bits remain
                if (sts.e_zero)
                    state_next = mexp_pkg::ST_FINISH;
                else if (sts.e_bit0)
                    state_next = mexp_pkg::ST_MUL;
                else
                    state_next = mexp_pkg::ST_SQR;
            end
            mexp_pkg::ST_MUL:
            begin
                cmd.op = mexp_pkg::OP_MUL;
                if (sts.mul_last)
                    state_next = mexp_pkg::ST_SQR;
            end
            mexp_pkg::ST_SQR:
            begin
                cmd.op = mexp_pkg::OP_SQR;
                if (sts.mul_last)
                begin
                    cmd.e_shift = 1'b1;
                    state_next  = mexp_pkg::ST_ROUND;
                end
            end
            mexp_pkg::ST_FINISH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = mexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == mexp_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ hdl/modular_exponentiation.sv @@
// Computation: the shared bit-serial modular multiplier, one multiplier bit per cycle, first reduces
//   the base, then for each exponent bit from the LSB multiplies (if the bit is set) and squares.
// Throughput: one transaction at a time; the next is taken while a result waits on out_ready.
// Reset: rst_n asynchronous, active low; clears control and sets the modulus to 1.
`timescale 1ns / 1ps

module modular_exponentiation #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             modulus_wr_en,
    input  logic [WIDTH-1:0] modulus_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] base_value,
    input  logic [WIDTH-1:0] exponent,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] power_result
);

    mexp_pkg::cmd_t cmd;
    mexp_pkg::sts_t sts;

    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mexp_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .modulus_wr_en   (modulus_wr_en),
        .modulus_wr_data (modulus_wr_data),
        .base_value      (base_value),
        .exponent        (exponent),
        .cmd             (cmd),
        .sts             (sts),
        .power_result    (power_result)
    );

endmodule

@@ hdl/mexp_checker.sv @@
`timescale 1ns / 1ps

module mexp_checker #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [WIDTH-1:0] power_result
);

    // Result holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(power_result))
        else $error("power_result changed while stalled");

    // Input is not taken again while base reduction is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##(WIDTH) !in_ready)
        else $error("input taken again too early");

    // A new result appears only as the block goes back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result raised while busy");

endmodule

bind modular_exponentiation mexp_checker #(
    .WIDTH (WIDTH)
) u_mexp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .power_result (power_result)
);
